// ===== rtl/lrp_pkg.sv =====
// ----------------------------------------------------------------------------
// lrp_pkg
// shared types, codes and constants of the line rotate and project block
// ----------------------------------------------------------------------------
package lrp_pkg;

   localparam int COORD_WIDTH_DEF    = 24;
   localparam int TRIG_FRAC_BITS_DEF = 15;

   // cos and sin of the fixed turn step in q1.30
   localparam longint COS_STEP_Q30 = 64'sd1057429446;
   localparam longint SIN_STEP_Q30 = 64'sd186452333;

   localparam int CMD_W      = 3;
   localparam int DIR_W      = 2;
   localparam int SHIFT_W    = 13;
   localparam int SHADE_W    = 8;
   localparam int SCREEN_W   = 16;
   localparam int VIEW_W     = 12;
   localparam int OFS_W      = 13;
   localparam int CENTER_W   = 10;
   localparam int CSR_W      = 13;
   localparam int CSR_IDX_W  = 2;

   localparam logic [VIEW_W-1:0]          VIEW_RESET = 12'd250;
   localparam logic signed [OFS_W-1:0]    OFS_RESET  = 13'sd0;
   localparam logic [CENTER_W-1:0]        CX_RESET   = 10'd319;
   localparam logic [CENTER_W-1:0]        CY_RESET   = 10'd200;

   typedef enum logic [CMD_W-1:0] {
      CMD_PROJECT = 3'd0,
      CMD_SHIFT   = 3'd1,
      CMD_ROT_X   = 3'd2,
      CMD_ROT_Y   = 3'd3,
      CMD_ROT_Z   = 3'd4
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_VIEW_DIST = 2'd0,
      REG_WORLD_OFS = 2'd1,
      REG_CENTER_X  = 2'd2,
      REG_CENTER_Y  = 2'd3
   } csr_index_type;

endpackage

// ===== rtl/lrp_req_if.sv =====
// ----------------------------------------------------------------------------
// lrp_req_if
// line word channel: command, two endpoints and palette index
// ----------------------------------------------------------------------------
interface lrp_req_if
   import lrp_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic [CMD_W-1:0]               cmd;
   logic signed [DIR_W-1:0]        direction;
   logic signed [SHIFT_W-1:0]      shift;
   logic signed [COORD_WIDTH-1:0]  ax;
   logic signed [COORD_WIDTH-1:0]  ay;
   logic signed [COORD_WIDTH-1:0]  az;
   logic signed [COORD_WIDTH-1:0]  bx;
   logic signed [COORD_WIDTH-1:0]  by;
   logic signed [COORD_WIDTH-1:0]  bz;
   logic [SHADE_W-1:0]             shade;

   modport source (output valid, cmd, direction, shift, ax, ay, az, bx, by, bz, shade,
                   input ready);
   modport sink   (input valid, cmd, direction, shift, ax, ay, az, bx, by, bz, shade,
                   output ready);
endinterface

// ===== rtl/lrp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lrp_rsp_if
// result word channel: transformed endpoints, screen points and flags
// ----------------------------------------------------------------------------
interface lrp_rsp_if
   import lrp_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [COORD_WIDTH-1:0]  new_ax;
   logic signed [COORD_WIDTH-1:0]  new_ay;
   logic signed [COORD_WIDTH-1:0]  new_az;
   logic signed [COORD_WIDTH-1:0]  new_bx;
   logic signed [COORD_WIDTH-1:0]  new_by;
   logic signed [COORD_WIDTH-1:0]  new_bz;
   logic signed [SCREEN_W-1:0]     screen_ax;
   logic signed [SCREEN_W-1:0]     screen_ay;
   logic signed [SCREEN_W-1:0]     screen_bx;
   logic signed [SCREEN_W-1:0]     screen_by;
   logic                           behind_eye;
   logic [SHADE_W-1:0]             shade_out;

   modport source (output valid, new_ax, new_ay, new_az, new_bx, new_by, new_bz,
                   screen_ax, screen_ay, screen_bx, screen_by, behind_eye, shade_out,
                   input ready);
   modport sink   (input valid, new_ax, new_ay, new_az, new_bx, new_by, new_bz,
                   screen_ax, screen_ay, screen_bx, screen_by, behind_eye, shade_out,
                   output ready);
endinterface

// ===== rtl/line_rotate_project_core.sv =====
// path: stages 1 to 3, divider entry, divider stages, output register
// throughput: one line per clock unless results stall; one word held per stage
// the divider is a four-lane restoring divider, three quotient bits a stage
// stalls only fill bubbles; a stage moves when the next one is empty or moving
// reset (synchronous, active high) empties every stage and loads register defaults
// ----------------------------------------------------------------------------
// line_rotate_project_core
// turns a 3d line by a fixed step or shifts its depth, then projects both
// endpoints onto the screen through a pipelined divider
// ----------------------------------------------------------------------------
module line_rotate_project_core
   import lrp_pkg::*;
#(
   parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
   parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   lrp_req_if.sink              req_ch,
   lrp_rsp_if.source            rsp_ch,
   input  logic                 csr_we,
   input  csr_index_type        csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // widths
   localparam int CW   = COORD_WIDTH;
   localparam int TF   = TRIG_FRAC_BITS;
   localparam int TW   = TF + 2;                       // trig constant width
   localparam int PVW  = OFS_W + 8;                    // pivot in q.8
   localparam int UW   = ((CW > PVW) ? CW : PVW) + 2;  // rotation operand
   localparam int MW   = UW + TW;                      // rotation product
   localparam int RW   = MW + 2;                       // rotation sum
   localparam int SW   = ((CW > VIEW_W + 8) ? CW : VIEW_W + 8) + 2; // depth sum
   localparam int HW   = SW - 8;                       // integer depth
   localparam int DW   = HW;                           // divisor magnitude
   localparam int PW   = CW + VIEW_W + 1;              // coord * distance
   localparam int NW   = CW + 3;                       // quotient bits needed
   localparam int BPS  = 3;                            // quotient bits per stage
   localparam int NDIV = (NW + BPS - 1) / BPS;
   localparam int XW   = NDIV * BPS;
   localparam int QSW  = XW + 2;

   localparam longint CQ = (COS_STEP_Q30 + (longint'(1) << (29 - TF))) >>> (30 - TF);
   localparam longint SQ = (SIN_STEP_Q30 + (longint'(1) << (29 - TF))) >>> (30 - TF);
   localparam logic signed [TW-1:0]  COS_C    = TW'(CQ);
   localparam logic signed [TW-1:0]  SIN_C    = TW'(SQ);
   localparam logic signed [RW-1:0]  RND_HALF = RW'(longint'(1) << (TF - 1));
   localparam logic signed [RW-1:0]  C_MAX    = RW'((longint'(1) << (CW - 1)) - 1);
   localparam logic signed [RW-1:0]  C_MIN    = -C_MAX - RW'(1);
   localparam logic signed [SW-1:0]  TZ_BIAS  = SW'(255);
   localparam logic signed [QSW-1:0] S_MAX    = QSW'(32767);
   localparam logic signed [QSW-1:0] S_MIN    = -S_MAX - QSW'(1);

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } pt_type;

   typedef struct packed {
      pt_type               a;
      pt_type               b;
      logic [SHADE_W-1:0]   shade;
      logic                 behind;
   } side_type;

   typedef struct packed {
      logic [XW-1:0]  num;
      logic [DW:0]    rem;
      logic [XW-1:0]  quo;
      logic [DW-1:0]  dm;
      logic           neg;
      logic           zero;
   } lane_type;

   // rounding and saturation of the turn
   function automatic logic signed [RW-1:0] rnd(input logic signed [RW-1:0] x);
      rnd = (x + RND_HALF) >>> TF;
   endfunction

   function automatic logic signed [CW-1:0] sat_c(input logic signed [RW-1:0] x);
      logic signed [RW-1:0] t;
      t = (x > C_MAX) ? C_MAX : ((x < C_MIN) ? C_MIN : x);
      sat_c = CW'(t);
   endfunction

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [VIEW_W-1:0]         view_ff;
   logic signed [OFS_W-1:0]   ofs_ff;
   logic [CENTER_W-1:0]       cx_ff;
   logic [CENTER_W-1:0]       cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         view_ff <= VIEW_RESET;
         ofs_ff  <= OFS_RESET;
         cx_ff   <= CX_RESET;
         cy_ff   <= CY_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_VIEW_DIST: view_ff <= csr_wdata[VIEW_W-1:0];
            REG_WORLD_OFS: ofs_ff  <= $signed(csr_wdata[OFS_W-1:0]);
            REG_CENTER_X:  cx_ff   <= csr_wdata[CENTER_W-1:0];
            REG_CENTER_Y:  cy_ff   <= csr_wdata[CENTER_W-1:0];
            default:       view_ff <= view_ff;
         endcase
      end
   end

   // pivot on the vertical axis, signed q13.8
   logic signed [UW-1:0] pivot_u;
   logic signed [RW-1:0] pivot_r;
   assign pivot_u = UW'($signed({ofs_ff, 8'b0}));
   assign pivot_r = RW'($signed({ofs_ff, 8'b0}));

   // ------------------------------------------------------------------
   // stage enables: a stage loads when it is empty or its word moves on
   // ------------------------------------------------------------------
   logic s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   logic en1, en2, en3, en_out;
   logic dv_v_ff [NDIV+1];
   logic dv_en   [NDIV+1];

   assign en_out = !out_v_ff || rsp_ch.ready;

   always_comb begin
      dv_en[NDIV] = !dv_v_ff[NDIV] || en_out;
      for (int k = NDIV - 1; k >= 0; k--) begin
         dv_en[k] = !dv_v_ff[k] || dv_en[k+1];
      end
   end

   assign en3 = !s3_v_ff || dv_en[0];
   assign en2 = !s2_v_ff || en3;
   assign en1 = !s1_v_ff || en2;
   assign req_ch.ready = en1;

   // ------------------------------------------------------------------
   // stage 1: pick the rotation pair and form the four products
   // ------------------------------------------------------------------
   logic [CMD_W-1:0]          s1_cmd_ff;
   logic                      s1_rot_ff, s1_neg_ff;
   logic signed [SHIFT_W-1:0] s1_shift_ff;
   logic [SHADE_W-1:0]        s1_shade_ff;
   pt_type                    s1_pt_ff [2];
   logic signed [MW-1:0]      s1_uc_ff [2], s1_vs_ff [2], s1_us_ff [2], s1_vc_ff [2];
   pt_type                    s1_pt_in [2];
   logic signed [MW-1:0]      s1_uc_in [2], s1_vs_in [2], s1_us_in [2], s1_vc_in [2];
   logic                      s1_rot_in;

   assign s1_pt_in[0] = '{x: req_ch.ax, y: req_ch.ay, z: req_ch.az};
   assign s1_pt_in[1] = '{x: req_ch.bx, y: req_ch.by, z: req_ch.bz};
   assign s1_rot_in   = (req_ch.direction != '0) &&
                        (req_ch.cmd == CMD_ROT_X || req_ch.cmd == CMD_ROT_Y ||
                         req_ch.cmd == CMD_ROT_Z);

   always_comb begin
      logic signed [UW-1:0] u, v;
      for (int e = 0; e < 2; e++) begin
         case (req_ch.cmd)
            CMD_ROT_X: begin
               u = pivot_u - UW'(s1_pt_in[e].z);
               v = UW'(s1_pt_in[e].y);
            end
            CMD_ROT_Y: begin
               u = pivot_u - UW'(s1_pt_in[e].z);
               v = UW'(s1_pt_in[e].x);
            end
            default: begin
               u = UW'(s1_pt_in[e].x);
               v = UW'(s1_pt_in[e].y);
            end
         endcase
         s1_uc_in[e] = MW'(u) * MW'(COS_C);
         s1_vs_in[e] = MW'(v) * MW'(SIN_C);
         s1_us_in[e] = MW'(u) * MW'(SIN_C);
         s1_vc_in[e] = MW'(v) * MW'(COS_C);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en1) begin
         s1_v_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_cmd_ff   <= req_ch.cmd;
         s1_rot_ff   <= s1_rot_in;
         s1_neg_ff   <= req_ch.direction[DIR_W-1];
         s1_shift_ff <= req_ch.shift;
         s1_shade_ff <= req_ch.shade;
         for (int e = 0; e < 2; e++) begin
            s1_pt_ff[e] <= s1_pt_in[e];
            s1_uc_ff[e] <= s1_uc_in[e];
            s1_vs_ff[e] <= s1_vs_in[e];
            s1_us_ff[e] <= s1_us_in[e];
            s1_vc_ff[e] <= s1_vc_in[e];
         end
      end
   end

   // ------------------------------------------------------------------
   // stage 2: depth shift, or sums, rounding, pivot back; saturation
   // ------------------------------------------------------------------
   pt_type             s2_pt_ff [2];
   logic [SHADE_W-1:0] s2_shade_ff;
   pt_type             s2_pt_in [2];

   always_comb begin
      logic signed [RW-1:0] vs_d, us_d, nu, nv;
      for (int e = 0; e < 2; e++) begin
         vs_d = s1_neg_ff ? -RW'(s1_vs_ff[e]) : RW'(s1_vs_ff[e]);
         us_d = s1_neg_ff ? -RW'(s1_us_ff[e]) : RW'(s1_us_ff[e]);
         nu   = rnd(RW'(s1_uc_ff[e]) - vs_d);
         nv   = rnd(us_d + RW'(s1_vc_ff[e]));
         s2_pt_in[e] = s1_pt_ff[e];
         if (s1_cmd_ff == CMD_SHIFT) begin
            s2_pt_in[e].y = sat_c(RW'(s1_pt_ff[e].y) + (RW'(s1_shift_ff) <<< 8));
         end else if (s1_rot_ff) begin
            case (s1_cmd_ff)
               CMD_ROT_X: begin
                  s2_pt_in[e].y = sat_c(nv);
                  s2_pt_in[e].z = sat_c(pivot_r - nu);
               end
               CMD_ROT_Y: begin
                  s2_pt_in[e].x = sat_c(nv);
                  s2_pt_in[e].z = sat_c(pivot_r - nu);
               end
               default: begin
                  s2_pt_in[e].x = sat_c(nu);
                  s2_pt_in[e].y = sat_c(nv);
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en2) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_pt_ff    <= s2_pt_in;
         s2_shade_ff <= s1_shade_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: integer depth (toward zero) and numerator products
   // ------------------------------------------------------------------
   pt_type                s3_pt_ff [2];
   logic [SHADE_W-1:0]    s3_shade_ff;
   logic signed [HW-1:0]  s3_h_ff [2];
   logic signed [PW-1:0]  s3_px_ff [2], s3_pz_ff [2];
   logic signed [HW-1:0]  s3_h_in [2];
   logic signed [PW-1:0]  s3_px_in [2], s3_pz_in [2];

   always_comb begin
      logic signed [SW-1:0] sum, hq;
      logic signed [PW-1:0] vdist;
      vdist = PW'($signed({1'b0, view_ff}));
      for (int e = 0; e < 2; e++) begin
         sum = SW'(s2_pt_ff[e].y) + SW'($signed({1'b0, view_ff, 8'b0}));
         hq  = (sum < 0) ? ((sum + TZ_BIAS) >>> 8) : (sum >>> 8);
         s3_h_in[e]  = HW'(hq);
         s3_px_in[e] = PW'(s2_pt_ff[e].x) * vdist;
         s3_pz_in[e] = PW'(s2_pt_ff[e].z) * vdist;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (en3) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_pt_ff    <= s2_pt_ff;
         s3_shade_ff <= s2_shade_ff;
         s3_h_ff     <= s3_h_in;
         s3_px_ff    <= s3_px_in;
         s3_pz_ff    <= s3_pz_in;
      end
   end

   // ------------------------------------------------------------------
   // divider entry: magnitudes and signs of the four lanes
   // lanes: a column, a row, b column, b row
   // ------------------------------------------------------------------
   side_type dv_side_ff [NDIV+1];
   lane_type dv_lane_ff [NDIV+1][4];
   side_type dv0_side_in;
   lane_type dv0_lane_in [4];

   always_comb begin
      logic signed [PW-1:0] num, nm;
      logic signed [HW-1:0] h, hm;
      for (int l = 0; l < 4; l++) begin
         num = (l[0] == 1'b0) ? s3_px_ff[l/2] : s3_pz_ff[l/2];
         h   = s3_h_ff[l/2];
         nm  = num[PW-1] ? -num : num;
         hm  = h[HW-1] ? -h : h;
         dv0_lane_in[l].num  = XW'(nm >> 8);
         dv0_lane_in[l].rem  = '0;
         dv0_lane_in[l].quo  = '0;
         dv0_lane_in[l].dm   = DW'(hm);
         dv0_lane_in[l].neg  = num[PW-1] ^ h[HW-1];
         dv0_lane_in[l].zero = (h == '0);
      end
      dv0_side_in.a      = s3_pt_ff[0];
      dv0_side_in.b      = s3_pt_ff[1];
      dv0_side_in.shade  = s3_shade_ff;
      dv0_side_in.behind = (s3_h_ff[0] <= 0) || (s3_h_ff[1] <= 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (dv_en[0]) begin
         dv_v_ff[0] <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (dv_en[0]) begin
         dv_side_ff[0] <= dv0_side_in;
         dv_lane_ff[0] <= dv0_lane_in;
      end
   end

   // ------------------------------------------------------------------
   // restoring divider, BPS quotient bits per stage
   // ------------------------------------------------------------------
   for (genvar k = 0; k < NDIV; k++) begin : g_div
      lane_type lane_in [4];

      always_comb begin
         lane_type t;
         logic     ge;
         for (int l = 0; l < 4; l++) begin
            t = dv_lane_ff[k][l];
            for (int j = 0; j < BPS; j++) begin
               t.rem = {t.rem[DW-1:0], t.num[XW-1]};
               t.num = {t.num[XW-2:0], 1'b0};
               ge    = (t.rem >= {1'b0, t.dm});
               if (ge) begin
                  t.rem = t.rem - {1'b0, t.dm};
               end
               t.quo = {t.quo[XW-2:0], ge};
            end
            lane_in[l] = t;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[k+1] <= 1'b0;
         end else if (dv_en[k+1]) begin
            dv_v_ff[k+1] <= dv_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (dv_en[k+1]) begin
            dv_side_ff[k+1] <= dv_side_ff[k];
            dv_lane_ff[k+1] <= lane_in;
         end
      end
   end

   // ------------------------------------------------------------------
   // output stage: sign, zero divisor, centre offset, screen saturation
   // ------------------------------------------------------------------
   side_type                    out_side_ff;
   logic signed [SCREEN_W-1:0]  out_scr_ff [4];
   logic signed [SCREEN_W-1:0]  out_scr_in [4];

   always_comb begin
      logic signed [QSW-1:0] qv, qs, sv;
      lane_type              ln;
      for (int l = 0; l < 4; l++) begin
         ln = dv_lane_ff[NDIV][l];
         qv = QSW'(ln.quo);
         qs = ln.zero ? '0 : (ln.neg ? -qv : qv);
         sv = qs + QSW'($signed({1'b0, (l[0] == 1'b0) ? cx_ff : cy_ff}));
         out_scr_in[l] = SCREEN_W'((sv > S_MAX) ? S_MAX : ((sv < S_MIN) ? S_MIN : sv));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en_out) begin
         out_v_ff <= dv_v_ff[NDIV];
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         out_side_ff <= dv_side_ff[NDIV];
         out_scr_ff  <= out_scr_in;
      end
   end

   assign rsp_ch.valid      = out_v_ff;
   assign rsp_ch.new_ax     = out_side_ff.a.x;
   assign rsp_ch.new_ay     = out_side_ff.a.y;
   assign rsp_ch.new_az     = out_side_ff.a.z;
   assign rsp_ch.new_bx     = out_side_ff.b.x;
   assign rsp_ch.new_by     = out_side_ff.b.y;
   assign rsp_ch.new_bz     = out_side_ff.b.z;
   assign rsp_ch.screen_ax  = out_scr_ff[0];
   assign rsp_ch.screen_ay  = out_scr_ff[1];
   assign rsp_ch.screen_bx  = out_scr_ff[2];
   assign rsp_ch.screen_by  = out_scr_ff[3];
   assign rsp_ch.behind_eye = out_side_ff.behind;
   assign rsp_ch.shade_out  = out_side_ff.shade;

endmodule

// ===== rtl/lrp_checker.sv =====
// ----------------------------------------------------------------------------
// lrp_checker
// port-level checks of the line rotate and project core
// ----------------------------------------------------------------------------
module lrp_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // output register empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // an empty output stage lets the whole pipe move
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output stage");

   // a taken result lets the whole pipe move
   a_taken_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while result taken");

   // a stalled result word stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

endmodule

bind line_rotate_project_core lrp_checker u_lrp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready)
);

// ===== test/line_rotate_project_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_rotate_project_core_test
// drives line words through the rotate and project core and compares every
// result word against a behavioural model, under random idling and stalls
// ----------------------------------------------------------------------------
module line_rotate_project_core_test;
   import lrp_pkg::*;

   typedef struct {
      logic [CMD_W-1:0]     cmd;
      logic signed [1:0]    direction;
      logic signed [12:0]   shift;
      logic signed [23:0]   ax, ay, az, bx, by, bz;
      logic [7:0]           shade;
   } line_word_type;

   typedef struct {
      logic signed [23:0]   new_ax, new_ay, new_az, new_bx, new_by, new_bz;
      logic signed [15:0]   screen_ax, screen_ay, screen_bx, screen_by;
      logic                 behind_eye;
      logic [7:0]           shade_out;
   } view_word_type;

   // ---------------------------------------------------------------------
   // scoreboard: predicts each line's view and checks results in order
   // ---------------------------------------------------------------------
   class view_scoreboard;
      view_word_type pending_views[$];
      longint     view_dist;
      longint     pivot_ofs;
      longint     ctr_x;
      longint     ctr_y;
      int         mismatches;
      int         checked;

      function void set_reg(csr_index_type idx, logic [12:0] val);
         case (idx)
            REG_VIEW_DIST: view_dist = val[11:0];
            REG_WORLD_OFS: pivot_ofs = $signed(val);
            REG_CENTER_X:  ctr_x = val[9:0];
            default:       ctr_y = val[9:0];
         endcase
      endfunction

      function longint round_off(longint x, int s);
         return (x + (longint'(1) <<< (s - 1))) >>> s;
      endfunction

      function longint sat24(longint x);
         if (x > 8388607) return 8388607;
         if (x < -8388608) return -8388608;
         return x;
      endfunction

      function longint sat16(longint x);
         if (x > 32767) return 32767;
         if (x < -32768) return -32768;
         return x;
      endfunction

      // turns (u, v) by one step in the given sense
      function void spin(inout longint u, inout longint v, input int sense);
         longint c, s, nu, nv;
         c = round_off(COS_STEP_Q30, 15);
         s = round_off(SIN_STEP_Q30, 15) * sense;
         nu = round_off(u * c - v * s, 15);
         nv = round_off(u * s + v * c, 15);
         u = nu;
         v = nv;
      endfunction

      function void move_point(input logic [2:0] cmd, input int sense, input longint sh,
                               inout longint p[3]);
         longint pv, u, v;
         pv = pivot_ofs * 256;
         if (cmd == CMD_SHIFT) begin
            p[1] = sat24(p[1] + sh * 256);
            return;
         end
         if (sense == 0 || cmd < CMD_ROT_X || cmd > CMD_ROT_Z) return;
         if (cmd == CMD_ROT_X) begin
            u = pv - p[2]; v = p[1];
            spin(u, v, sense);
            p[1] = sat24(v); p[2] = sat24(pv - u);
         end else if (cmd == CMD_ROT_Y) begin
            u = pv - p[2]; v = p[0];
            spin(u, v, sense);
            p[0] = sat24(v); p[2] = sat24(pv - u);
         end else begin
            u = p[0]; v = p[1];
            spin(u, v, sense);
            p[0] = sat24(u); p[1] = sat24(v);
         end
      endfunction

      function void project_point(input longint p[3], output longint col,
                                  output longint row, inout bit behind);
         longint h, qx, qy;
         h = (p[1] + view_dist * 256) / 256;
         qx = 0;
         qy = 0;
         if (h <= 0) behind = 1;
         if (h != 0) begin
            qx = (p[0] * view_dist) / (h * 256);
            qy = (p[2] * view_dist) / (h * 256);
         end
         col = sat16(qx + ctr_x);
         row = sat16(qy + ctr_y);
      endfunction

      function void note_line(line_word_type w);
         longint pa[3], pb[3];
         longint c0, r0, c1, r1;
         int sense;
         bit behind;
         view_word_type e;
         sense = (w.direction > 0) ? 1 : ((w.direction < 0) ? -1 : 0);
         pa[0] = w.ax; pa[1] = w.ay; pa[2] = w.az;
         pb[0] = w.bx; pb[1] = w.by; pb[2] = w.bz;
         move_point(w.cmd, sense, w.shift, pa);
         move_point(w.cmd, sense, w.shift, pb);
         behind = 0;
         project_point(pa, c0, r0, behind);
         project_point(pb, c1, r1, behind);
         e.new_ax = pa[0]; e.new_ay = pa[1]; e.new_az = pa[2];
         e.new_bx = pb[0]; e.new_by = pb[1]; e.new_bz = pb[2];
         e.screen_ax = c0; e.screen_ay = r0; e.screen_bx = c1; e.screen_by = r1;
         e.behind_eye = behind;
         e.shade_out = w.shade;
         pending_views.push_back(e);
      endfunction

      function void check_view(view_word_type got);
         view_word_type e;
         checked++;
         if (pending_views.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
            return;
         end
         e = pending_views.pop_front();
         if (got != e) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch at %0t", $realtime);
               $display("  exp %p", e);
               $display("  got %p", got);
            end
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   csr_index_type csr_index = REG_VIEW_DIST;
   logic [CSR_W-1:0] csr_wdata = '0;

   lrp_req_if req_ch ();
   lrp_rsp_if rsp_ch ();

   line_rotate_project_core dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   view_scoreboard board;
   bit  calm_tail;      // no idling in the final stretch
   int  hold_off;       // long receiver stall, counted by the sink process
   int  lines_sent;

   initial begin
      forever #2 clock = ~clock;
   end

   // sink side: random stalls, one long hold-off on request
   initial begin
      int gap;
      rsp_ch.ready = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp_ch.ready <= 0;
            hold_off--;
         end else if (!calm_tail && $urandom_range(0, 15) == 0) begin
            gap = $urandom_range(1, 12);
            rsp_ch.ready <= 0;
            repeat (gap - 1) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1;
         end
      end
   end

   // result words are sampled at the rising edge
   always @(posedge clock) begin
      view_word_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.new_ax = rsp_ch.new_ax; got.new_ay = rsp_ch.new_ay; got.new_az = rsp_ch.new_az;
         got.new_bx = rsp_ch.new_bx; got.new_by = rsp_ch.new_by; got.new_bz = rsp_ch.new_bz;
         got.screen_ax = rsp_ch.screen_ax; got.screen_ay = rsp_ch.screen_ay;
         got.screen_bx = rsp_ch.screen_bx; got.screen_by = rsp_ch.screen_by;
         got.behind_eye = rsp_ch.behind_eye;
         got.shade_out = rsp_ch.shade_out;
         board.check_view(got);
      end
   end

   // offers one line word and waits for it to be taken; valid stays high
   // between back-to-back words
   task automatic send_line(line_word_type w);
      int gap;
      if (!calm_tail && $urandom_range(0, 11) == 0) begin
         gap = $urandom_range(1, 12);
         req_ch.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1;
      req_ch.cmd <= w.cmd; req_ch.direction <= w.direction; req_ch.shift <= w.shift;
      req_ch.ax <= w.ax; req_ch.ay <= w.ay; req_ch.az <= w.az;
      req_ch.bx <= w.bx; req_ch.by <= w.by; req_ch.bz <= w.bz;
      req_ch.shade <= w.shade;
      do @(posedge clock); while (!req_ch.ready);
      board.note_line(w);
      lines_sent++;
      @(negedge clock);
   endtask

   task automatic drain_and_idle();
      req_ch.valid <= 0;
      while (board.pending_views.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_W-1:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      board.set_reg(idx, val);
      @(negedge clock);
   endtask

   function automatic logic signed [23:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 24'($urandom);                             // full range
         1: return $signed(24'($urandom_range(0, 6)) - 24'sd3) <<< 22;
         default: return $signed(24'($urandom_range(0, 131072))) - 24'sd65536;
      endcase
   endfunction

   function automatic line_word_type rand_line();
      line_word_type w;
      w.cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
      w.direction = 2'($urandom);
      w.shift = 13'($urandom);
      w.ax = rand_coord(); w.ay = rand_coord(); w.az = rand_coord();
      w.bx = rand_coord(); w.by = rand_coord(); w.bz = rand_coord();
      w.shade = 8'($urandom);
      return w;
   endfunction

   function automatic line_word_type make_line(logic [2:0] cmd, logic signed [1:0] dir,
                                               logic signed [23:0] v, logic signed [23:0] d);
      line_word_type w;
      w.cmd = cmd; w.direction = dir; w.shift = 13'sd100;
      w.ax = v; w.ay = d; w.az = -v;
      w.bx = -v; w.by = d; w.bz = v;
      w.shade = 8'hA5;
      return w;
   endfunction

   initial begin
      line_word_type w;
      int phase;
      board = new();
      board.set_reg(REG_VIEW_DIST, VIEW_RESET);
      board.set_reg(REG_WORLD_OFS, OFS_RESET);
      board.set_reg(REG_CENTER_X, CX_RESET);
      board.set_reg(REG_CENTER_Y, CY_RESET);
      req_ch.valid = 0;
      req_ch.cmd = CMD_PROJECT; req_ch.direction = 0; req_ch.shift = 0;
      req_ch.ax = 0; req_ch.ay = 0; req_ch.az = 0;
      req_ch.bx = 0; req_ch.by = 0; req_ch.bz = 0;
      req_ch.shade = 0;
      repeat (10) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: each command, both senses, saturation corners, eye plane
      send_line(make_line(CMD_PROJECT, 2'sd0, 24'sd25600, 24'sd0));
      send_line(make_line(CMD_SHIFT, 2'sd0, 24'sd1000, 24'sd8388000));     // saturates high
      send_line(make_line(CMD_ROT_X, 2'sd1, 24'sd5000, 24'sd12800));
      send_line(make_line(CMD_ROT_X, -2'sd1, 24'sd5000, 24'sd12800));
      send_line(make_line(CMD_ROT_Y, 2'sd1, 24'sd7000, -24'sd2560));
      send_line(make_line(CMD_ROT_Y, -2'sd2, 24'sd7000, -24'sd2560));     // minus two as minus one
      send_line(make_line(CMD_ROT_Z, 2'sd1, 24'sd9000, 24'sd3000));
      send_line(make_line(CMD_ROT_Z, 2'sd0, 24'sd9000, 24'sd3000));       // no turn
      send_line(make_line(3'd5, 2'sd1, 24'sd9000, 24'sd3000));            // unused codes
      send_line(make_line(3'd7, -2'sd1, 24'sd9000, 24'sd3000));
      send_line(make_line(CMD_ROT_Z, 2'sd1, 24'sh7FFFFF, 24'sh7FFFFF));   // saturation
      send_line(make_line(CMD_ROT_X, -2'sd1, 24'sh800000, 24'sh800000));
      send_line(make_line(CMD_PROJECT, 2'sd0, 24'sd64000, -24'sd64000));  // zero divisor
      send_line(make_line(CMD_PROJECT, 2'sd0, 24'sd64000, -24'sd128000)); // behind the eye
      send_line(make_line(CMD_PROJECT, 2'sd0, 24'sh7FFFFF, -24'sd63800)); // depth under one unit: zero divisor
      w = make_line(CMD_SHIFT, 2'sd0, 24'sd100, 24'sd0);
      w.shift = -13'sd4096; w.shade = 8'h00;
      send_line(w);
      w.shift = 13'sd4095; w.shade = 8'hFF;
      send_line(w);
      drain_and_idle();

      // several register settings, extremes included
      for (phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin
               write_reg(REG_VIEW_DIST, 13'd1);    write_reg(REG_WORLD_OFS, 13'h1000);
               write_reg(REG_CENTER_X, 13'd0);     write_reg(REG_CENTER_Y, 13'd0);
            end
            1: begin
               write_reg(REG_VIEW_DIST, 13'd4095); write_reg(REG_WORLD_OFS, 13'h0FFF);
               write_reg(REG_CENTER_X, 13'd1023);  write_reg(REG_CENTER_Y, 13'd1023);
            end
            2: write_reg(REG_VIEW_DIST, 13'd0);
            default: begin
               write_reg(REG_VIEW_DIST, 13'($urandom_range(1, 4095)));
               write_reg(REG_WORLD_OFS, 13'($urandom));
               write_reg(REG_CENTER_X, 13'($urandom_range(0, 1023)));
               write_reg(REG_CENTER_Y, 13'($urandom_range(0, 1023)));
            end
         endcase
         if (phase == 6) calm_tail = 1;
         // receiver holds off while lines keep coming, filling the pipeline
         if (phase == 3) hold_off = 60;
         repeat (200) send_line(rand_line());
         drain_and_idle();
      end

      $display("covered %0d lines, %0d results checked, 7 register settings",
               lines_sent, board.checked);
      if (board.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", board.mismatches);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // run limit, far beyond the slowest correct run
   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
